[rtl/core/vts_pkg.sv]
// -----------------------------------------------------------------------------
// vts_pkg - shared types and constants for the virtual timer scheduler
// Field widths, operation codes and sequencer states.
// -----------------------------------------------------------------------------
package vts_pkg;

    localparam int unsigned ID_W   = 4;
    localparam int unsigned DATA_W = 32;

    // operation codes carried in the opcode field
    localparam logic OP_TICK = 1'b0;
    localparam logic OP_ADD  = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_EVAL,
        ST_FLUSH
    } t_vts_state;

endpackage : vts_pkg

[rtl/core/vts_if.sv]
// -----------------------------------------------------------------------------
// vts_if - word channels of the virtual timer scheduler
// Command channel (tick or add) and firing channel, valid/ready handshake.
// -----------------------------------------------------------------------------
interface vts_in_if;
    logic                        valid;
    logic                        ready;
    logic                        opcode;
    logic [vts_pkg::ID_W-1:0]    timer_id;
    logic [vts_pkg::DATA_W-1:0]  period;
    logic [vts_pkg::DATA_W-1:0]  run_count;

    modport source (output valid, opcode, timer_id, period, run_count, input ready);
    modport sink   (input valid, opcode, timer_id, period, run_count, output ready);
endinterface : vts_in_if

interface vts_out_if;
    logic                        valid;
    logic                        ready;
    logic [vts_pkg::ID_W-1:0]    fired_id;
    logic [vts_pkg::DATA_W-1:0]  runs_left;
    logic                        retired;
    logic                        last;

    modport source (output valid, fired_id, runs_left, retired, last, input ready);
    modport sink   (input valid, fired_id, runs_left, retired, last, output ready);
endinterface : vts_out_if

[rtl/core/virtual_timer_scheduler_unit.sv]
// -----------------------------------------------------------------------------
// virtual_timer_scheduler_unit - tick counter with a table of repeating timers
// Arms timer slots and, on each tick, reports every slot that falls due.
// -----------------------------------------------------------------------------
// An add word is written into its slot as it is accepted: deadline = tick +
// period (a zero period counts as one), and the slot is marked active; an id
// at or above NUM_TIMERS is dropped. A tick word bumps the 32-bit counter and
// then scans the slots in ascending order, each with an address step and then
// a compare and write-back step, through one read port of the slot table and
// one shared 32-bit adder. A final flush ends the scan; a stall on the firing
// channel can hold it, and no word is taken during the scan or the flush.
// Each due slot yields one firing word; the last word of a tick is held back
// one hit so that it can carry the last flag. A tick with nothing due yields
// nothing. A run count of one retires the slot, zero repeats for ever, larger
// counts count down and the slot re-arms at tick + period.
// Deadlines are always strictly ahead and checked every tick, so the due test
// is an equality and survives counter wrap.
// -----------------------------------------------------------------------------
module virtual_timer_scheduler_unit #(
    parameter int unsigned NUM_TIMERS = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    vts_in_if.sink        i_in,
    vts_out_if.source     o_out
);
    import vts_pkg::*;

    localparam int unsigned IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_TIMERS - 1);

    // sequencer
    t_vts_state          r_state, n_state;
    logic [IDX_W-1:0]    r_idx, n_idx;
    logic [DATA_W-1:0]   r_tick;

    // slot table: active bits in flops, the rest in memory
    logic [NUM_TIMERS-1:0] r_active;
    logic [DATA_W-1:0]     m_deadline [NUM_TIMERS];
    logic [DATA_W-1:0]     m_period   [NUM_TIMERS];
    logic [DATA_W-1:0]     m_runs     [NUM_TIMERS];
    logic [DATA_W-1:0]     r_rd_deadline, r_rd_period, r_rd_runs;

    // pending firing, held until the next hit or the end of the scan
    logic                  r_pend_valid;
    logic [ID_W-1:0]       r_pend_id;
    logic [DATA_W-1:0]     r_pend_runs;
    logic                  r_pend_ret;

    // output register
    logic                  r_out_valid;
    logic [ID_W-1:0]       r_out_id;
    logic [DATA_W-1:0]     r_out_runs;
    logic                  r_out_ret;
    logic                  r_out_last;

    // control
    logic                  in_acc;
    logic                  add_hit;
    logic                  out_free;
    logic                  due;
    logic                  retire;
    logic                  advance;
    logic                  hit_take;
    logic                  push;
    logic                  push_last;
    logic                  wr_en;
    logic [IDX_W-1:0]      wr_idx;
    logic [DATA_W-1:0]     per_fix;
    logic [DATA_W-1:0]     add_b;
    logic [DATA_W-1:0]     sum;
    logic [DATA_W-1:0]     new_runs;
    logic [DATA_W-1:0]     wr_period;
    logic [DATA_W-1:0]     wr_runs;

    assign i_in.ready = (r_state == ST_IDLE);
    assign in_acc     = i_in.valid && i_in.ready;
    assign add_hit    = in_acc && (i_in.opcode == OP_ADD)
                        && (32'(i_in.timer_id) < 32'(NUM_TIMERS));
    assign out_free   = !r_out_valid || o_out.ready;

    // shared adder: tick + period for an add, tick + stored period on re-arm
    assign per_fix = (i_in.period == '0) ? DATA_W'(1) : i_in.period;
    assign add_b   = (r_state == ST_IDLE) ? per_fix : r_rd_period;
    assign sum     = r_tick + add_b;

    assign due      = r_active[r_idx] && (r_rd_deadline == r_tick);
    assign retire   = (r_rd_runs == DATA_W'(1));
    assign new_runs = (r_rd_runs > DATA_W'(1)) ? (r_rd_runs - DATA_W'(1)) : r_rd_runs;

    always_comb begin
        n_state   = r_state;
        n_idx     = r_idx;
        advance   = 1'b0;
        hit_take  = 1'b0;
        push      = 1'b0;
        push_last = 1'b0;
        wr_en     = 1'b0;
        wr_idx    = r_idx;
        wr_period = r_rd_period;
        wr_runs   = retire ? '0 : new_runs;
        unique case (r_state)
            ST_IDLE: begin
                wr_idx    = IDX_W'(i_in.timer_id);
                wr_period = per_fix;
                wr_runs   = i_in.run_count;
                wr_en     = add_hit;
                if (in_acc && (i_in.opcode == OP_TICK)) begin
                    n_idx   = '0;
                    n_state = ST_READ;
                end
            end
            ST_READ: begin
                n_state = ST_EVAL;
            end
            ST_EVAL: begin
                // a second hit needs the output register to release the first
                advance  = !due || !r_pend_valid || out_free;
                hit_take = due && advance;
                push     = hit_take && r_pend_valid;
                wr_en    = hit_take;
                if (advance) begin
                    if (r_idx == LAST_IDX) begin
                        n_state = ST_FLUSH;
                    end else begin
                        n_idx   = r_idx + IDX_W'(1);
                        n_state = ST_READ;
                    end
                end
            end
            ST_FLUSH: begin
                if (!r_pend_valid) begin
                    n_state = ST_IDLE;
                end else if (out_free) begin
                    push      = 1'b1;
                    push_last = 1'b1;
                    n_state   = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_idx        <= '0;
            r_tick       <= '0;
            r_active     <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            if (in_acc && (i_in.opcode == OP_TICK)) begin
                r_tick <= r_tick + DATA_W'(1);
            end
            if (add_hit) begin
                r_active[wr_idx] <= 1'b1;
            end else if (hit_take && retire) begin
                r_active[r_idx] <= 1'b0;
            end
            if (hit_take) begin
                r_pend_valid <= 1'b1;
            end else if (push) begin
                r_pend_valid <= 1'b0;
            end
            if (push) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload, no reset
    always_ff @(posedge i_clk) begin
        if (hit_take) begin
            r_pend_id   <= ID_W'(r_idx);
            r_pend_runs <= retire ? '0 : new_runs;
            r_pend_ret  <= retire;
        end
        if (push) begin
            r_out_id   <= r_pend_id;
            r_out_runs <= r_pend_runs;
            r_out_ret  <= r_pend_ret;
            r_out_last <= push_last;
        end
    end

    // slot table, one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            m_deadline[wr_idx] <= sum;
            m_period[wr_idx]   <= wr_period;
            m_runs[wr_idx]     <= wr_runs;
        end
        r_rd_deadline <= m_deadline[r_idx];
        r_rd_period   <= m_period[r_idx];
        r_rd_runs     <= m_runs[r_idx];
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.fired_id  = r_out_id;
    assign o_out.runs_left = r_out_runs;
    assign o_out.retired   = r_out_ret;
    assign o_out.last      = r_out_last;

`ifndef SYNTH
    a_idle_no_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> !r_pend_valid)
        else $error("pending firing left over after scan");

    a_tick_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && (i_in.opcode == OP_TICK)) |=> (r_tick == $past(r_tick) + DATA_W'(1)))
        else $error("tick counter did not step");

    a_retired_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.retired) |-> (o_out.runs_left == '0))
        else $error("retired firing with non-zero run count");

    a_flush_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FLUSH && r_pend_valid && out_free)
            |=> (r_state == ST_IDLE && o_out.valid && o_out.last))
        else $error("final firing of tick not flagged last");

    a_hold_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EVAL && !advance) |=> (r_state == ST_EVAL && $stable(r_idx)))
        else $error("scan moved while stalled");
`endif

endmodule : virtual_timer_scheduler_unit

[verif/tb_virtual_timer_scheduler_unit.sv]
// -----------------------------------------------------------------------------
// tb_virtual_timer_scheduler_unit - self-checking bench for the timer scheduler
// Drives add and tick words and predicts every firing word from a local slot
// table. Each firing is checked field by field. Both channels idle at random,
// and one stretch holds the firing channel off until the block backs up.
// -----------------------------------------------------------------------------
module tb_virtual_timer_scheduler_unit;

    import vts_pkg::*;

    localparam int unsigned NUM_TIMERS = 16;
    // cycles with nothing accepted on either channel before the run is abandoned
    localparam int unsigned STUCK_LIMIT = 2000;
    // one full slot scan plus margin
    localparam int unsigned SCAN_CYCLES = 2 * NUM_TIMERS + 8;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [DATA_W-1:0] left;
        logic              retired;
        logic              last;
    } t_firing;

    logic i_clk;
    logic i_rst_n;

    vts_in_if  cmd_if ();
    vts_out_if fire_if ();

    virtual_timer_scheduler_unit #(
        .NUM_TIMERS (NUM_TIMERS)
    ) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (cmd_if),
        .o_out   (fire_if)
    );

    // predicted slot table, mirrors what the block should hold
    logic [DATA_W-1:0] model_tick;
    logic [DATA_W-1:0] slot_due_at   [NUM_TIMERS];
    logic [DATA_W-1:0] slot_interval [NUM_TIMERS];
    logic [DATA_W-1:0] slot_runs_left[NUM_TIMERS];
    logic              slot_armed    [NUM_TIMERS];

    t_firing     due_firings[$];    // firings predicted but not yet seen
    int unsigned error_count;
    bit          steady;            // no idling on either side once set
    int unsigned hold_off_request;  // long receiver stall, consumed by the sink

    // -------------------------------------------------------------------------
    // Clock
    // -------------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // -------------------------------------------------------------------------
    // Mismatch reporting
    // -------------------------------------------------------------------------
    task automatic report_mismatch(input string what);
        error_count++;
        $display("ERROR @%0t: %s", $time, what);
    endtask

    // -------------------------------------------------------------------------
    // Slot table prediction: an add arms a slot, a tick advances the counter
    // and queues one firing per slot whose deadline equals the new count.
    // -------------------------------------------------------------------------
    task automatic schedule_word(input logic op, input logic [ID_W-1:0] id,
                                 input logic [DATA_W-1:0] per,
                                 input logic [DATA_W-1:0] runs);
        t_firing     f;
        int unsigned queued_before;
        if (op == OP_ADD) begin
            // ids above the table are dropped; unreachable at sixteen slots
            if (id < NUM_TIMERS) begin
                if (per == '0)
                    per = 1;           // zero period behaves as one
                slot_due_at[id]    = model_tick + per;
                slot_interval[id]  = per;
                slot_runs_left[id] = runs;
                slot_armed[id]     = 1'b1;
            end
        end else begin
            model_tick    = model_tick + 1;
            queued_before = due_firings.size();
            for (int s = 0; s < NUM_TIMERS; s++) begin
                if (slot_armed[s] && slot_due_at[s] == model_tick) begin
                    f.id   = ID_W'(s);
                    f.last = 1'b0;
                    if (slot_runs_left[s] == 1) begin
                        slot_armed[s]     = 1'b0;
                        slot_runs_left[s] = '0;
                        f.left            = '0;
                        f.retired         = 1'b1;
                    end else begin
                        // zero repeats for ever, larger counts count down
                        if (slot_runs_left[s] > 1)
                            slot_runs_left[s] = slot_runs_left[s] - 1;
                        slot_due_at[s] = model_tick + slot_interval[s];
                        f.left         = slot_runs_left[s];
                        f.retired      = 1'b0;
                    end
                    due_firings.push_back(f);
                end
            end
            if (due_firings.size() > queued_before)
                due_firings[$].last = 1'b1;
        end
    endtask

    // -------------------------------------------------------------------------
    // Command side: one word per call, optional idle burst ahead of it.
    // Driven on the falling edge, accepted on the rising edge.
    // -------------------------------------------------------------------------
    task automatic send_word(input logic op, input logic [ID_W-1:0] id,
                             input logic [DATA_W-1:0] per,
                             input logic [DATA_W-1:0] runs);
        int unsigned gap;
        gap = 0;
        if (!steady && $urandom_range(0, 3) == 0)
            gap = $urandom_range(1, 4);
        if (gap != 0) begin
            @(negedge i_clk);
            cmd_if.valid = 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        cmd_if.valid     = 1'b1;
        cmd_if.opcode    = op;
        cmd_if.timer_id  = id;
        cmd_if.period    = per;
        cmd_if.run_count = runs;
        do
            @(posedge i_clk);
        while (!cmd_if.ready);
        schedule_word(op, id, per, runs);
    endtask

    // tick fields are ignored by the block, so fill them with noise
    task automatic send_tick();
        send_word(OP_TICK, ID_W'($urandom), $urandom, $urandom);
    endtask

    // -------------------------------------------------------------------------
    // Firing side: random stall bursts, plus the long hold-off on request
    // -------------------------------------------------------------------------
    initial begin
        int unsigned stall;
        fire_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_off_request != 0) begin
                stall            = hold_off_request;
                hold_off_request = 0;
                fire_if.ready    = 1'b0;
                repeat (stall - 1) @(negedge i_clk);
            end else if (!steady && $urandom_range(0, 4) == 0) begin
                fire_if.ready = 1'b0;
                repeat ($urandom_range(1, 4) - 1) @(negedge i_clk);
            end else begin
                fire_if.ready = 1'b1;
            end
        end
    end

    // -------------------------------------------------------------------------
    // Firing checker: every accepted word against the oldest prediction
    // -------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_firing got;
        t_firing want;
        if (i_rst_n && fire_if.valid && fire_if.ready) begin
            got.id      = fire_if.fired_id;
            got.left    = fire_if.runs_left;
            got.retired = fire_if.retired;
            got.last    = fire_if.last;
            if (due_firings.size() == 0) begin
                report_mismatch($sformatf("unexpected firing id=%0d left=%0d ret=%b last=%b",
                                          got.id, got.left, got.retired, got.last));
            end else begin
                want = due_firings.pop_front();
                if (got.id !== want.id)
                    report_mismatch($sformatf("fired_id %0d, want %0d", got.id, want.id));
                if (got.left !== want.left)
                    report_mismatch($sformatf("runs_left %0d, want %0d (id %0d)",
                                              got.left, want.left, want.id));
                if (got.retired !== want.retired)
                    report_mismatch($sformatf("retired %b, want %b (id %0d)",
                                              got.retired, want.retired, want.id));
                if (got.last !== want.last)
                    report_mismatch($sformatf("last %b, want %b (id %0d)",
                                              got.last, want.last, want.id));
            end
        end
    end

    // -------------------------------------------------------------------------
    // Watchdog: consecutive cycles with no word moving on either channel
    // -------------------------------------------------------------------------
    initial begin
        int unsigned idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STUCK_LIMIT) begin
            @(posedge i_clk);
            if ((cmd_if.valid && cmd_if.ready) || (fire_if.valid && fire_if.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("watchdog: no word moved for %0d cycles", STUCK_LIMIT);
        $display("virtual_timer_scheduler_unit verification failed");
        $finish;
    end

    // -------------------------------------------------------------------------
    // Directed tests
    // -------------------------------------------------------------------------

    // run count of one: fires once and retires
    task automatic test_one_shot();
        send_word(OP_ADD, 4'd0, 32'd1, 32'd1);
        send_tick();
    endtask

    // zero period is taken as one; a count of two counts down then retires
    task automatic test_zero_period_countdown();
        send_word(OP_ADD, 4'd1, 32'd0, 32'd2);
        send_tick();
        send_tick();
    endtask

    // endless repeat on the top slot, then an add over the live slot
    task automatic test_forever_and_overwrite();
        send_word(OP_ADD, 4'd15, 32'd2, 32'd0);
        send_tick();
        send_tick();
        send_word(OP_ADD, 4'd15, 32'd1, 32'd1);
        send_tick();
    endtask

    // all-ones period wraps the deadline to just behind the count, so it
    // never comes due here; all-ones run count decrements once
    task automatic test_field_extremes();
        send_word(OP_ADD, 4'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_word(OP_ADD, 4'd8, 32'd1, 32'hFFFF_FFFF);
        send_tick();
        send_word(OP_ADD, 4'd8, 32'd1, 32'd1);
        send_tick();
        send_word(OP_ADD, 4'd7, 32'd1, 32'd1);
        send_tick();
    endtask

    // several due on one tick: ascending slot order, last flag on the final
    // one; the tick after has nothing due
    task automatic test_same_tick_order();
        send_word(OP_ADD, 4'd12, 32'd1, 32'd1);
        send_word(OP_ADD, 4'd3, 32'd1, 32'd1);
        send_word(OP_ADD, 4'd5, 32'd1, 32'd1);
        send_tick();
        send_tick();
    endtask

    // firing side held off while ticks keep coming: the block must back up
    // and refuse commands until the stall clears
    task automatic test_backpressure();
        send_word(OP_ADD, 4'd2, 32'd1, 32'd0);
        send_word(OP_ADD, 4'd9, 32'd1, 32'd0);
        send_word(OP_ADD, 4'd14, 32'd1, 32'd0);
        hold_off_request = 300;
        repeat (4) send_tick();
        send_word(OP_ADD, 4'd2, 32'd1, 32'd1);
        send_word(OP_ADD, 4'd9, 32'd1, 32'd1);
        send_word(OP_ADD, 4'd14, 32'd1, 32'd1);
        send_tick();
    endtask

    // -------------------------------------------------------------------------
    // Random traffic: mostly bursts of adds followed by a few ticks, so slots
    // really come due; the odd lone word is thrown in as noise
    // -------------------------------------------------------------------------
    function automatic logic [DATA_W-1:0] pick_period();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return $urandom;
            2:       return 32'hFFFF_FFFF;
            default: return $urandom_range(1, 5);
        endcase
    endfunction

    function automatic logic [DATA_W-1:0] pick_runs();
        case ($urandom_range(0, 9))
            0, 1:    return '0;
            2:       return $urandom;
            3:       return 32'hFFFF_FFFF;
            default: return $urandom_range(1, 3);
        endcase
    endfunction

    task automatic test_random_schedule(input int unsigned words_wanted);
        int unsigned sent;
        int unsigned n_add;
        int unsigned n_tick;
        sent = 0;
        while (sent < words_wanted) begin
            if ($urandom_range(0, 7) == 0) begin
                if ($urandom_range(0, 1) == 0)
                    send_tick();
                else
                    send_word(OP_ADD, ID_W'($urandom), $urandom, $urandom);
                sent++;
            end
            if ($urandom_range(0, 11) == 0) begin
                // every slot due on the next tick: the fullest burst
                for (int s = 0; s < NUM_TIMERS; s++)
                    send_word(OP_ADD, ID_W'(s), $urandom_range(0, 1), pick_runs());
                sent += NUM_TIMERS;
            end else begin
                n_add = $urandom_range(1, 4);
                repeat (n_add)
                    send_word(OP_ADD, ID_W'($urandom), pick_period(), pick_runs());
                sent += n_add;
            end
            n_tick = $urandom_range(1, 6);
            repeat (n_tick) send_tick();
            sent += n_tick;
        end
    endtask

    // closing stretch with no idling on either side
    task automatic test_steady_flow();
        steady = 1'b1;
        test_random_schedule(60);
    endtask

    // release the command channel and let the last scan finish
    task automatic finish_traffic();
        @(negedge i_clk);
        cmd_if.valid = 1'b0;
        while (due_firings.size() != 0)
            @(posedge i_clk);
        repeat (SCAN_CYCLES) @(posedge i_clk);
    endtask

    // -------------------------------------------------------------------------
    // Test sequence
    // -------------------------------------------------------------------------
    initial begin
        i_rst_n          = 1'b0;
        cmd_if.valid     = 1'b0;
        cmd_if.opcode    = OP_TICK;
        cmd_if.timer_id  = '0;
        cmd_if.period    = '0;
        cmd_if.run_count = '0;
        error_count      = 0;
        steady           = 1'b0;
        hold_off_request = 0;
        model_tick       = '0;
        for (int s = 0; s < NUM_TIMERS; s++) begin
            slot_armed[s]     = 1'b0;
            slot_due_at[s]    = '0;
            slot_interval[s]  = '0;
            slot_runs_left[s] = '0;
        end
        repeat (2) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_one_shot();
        test_zero_period_countdown();
        test_forever_and_overwrite();
        test_field_extremes();
        test_same_tick_order();
        test_backpressure();
        test_random_schedule(160);
        test_steady_flow();
        finish_traffic();

        if (error_count == 0)
            $display("virtual_timer_scheduler_unit verification clean");
        else
            $display("virtual_timer_scheduler_unit verification failed");
        $finish;
    end

endmodule : tb_virtual_timer_scheduler_unit

[files.f]
rtl/core/vts_pkg.sv
rtl/core/vts_if.sv
rtl/core/virtual_timer_scheduler_unit.sv
verif/tb_virtual_timer_scheduler_unit.sv
